// File: hw/rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W  = 16;
    localparam int PCT_IN_W = 8;
    localparam int PCT_W  = 7;     // clamped percent, 0..100
    localparam int CHAN_W = 8;
    localparam int DIST_W = 6;     // distance from the sector pair's midpoint, 0..60
    localparam int NUM_W  = 20;    // channel numerator over 600000

    // Default depth of the queue between the front and the back
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Hue reduction: offset that makes any 16-bit hue non-negative, and the
    // reciprocal of 360 scaled by 2^25 (exact for 17-bit dividends).
    localparam int HUE_OFFSET     = 33120;    // 92 * 360
    localparam int HUE_RECIP      = 93207;
    localparam int HUE_RECIP_SH   = 25;

    // Channel rounding: (255*N + 300000) / 600000 == (17*N + 20000) / 40000,
    // done as a shift by 6 and a reciprocal multiply for 625.
    localparam int ROUND_BIAS     = 20000;
    localparam int ROUND_RECIP    = 429497;
    localparam int ROUND_RECIP_SH = 28;

    // Hue sectors of 60 degrees each
    localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
    localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
    localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
    localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
    localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

    // One classified item as it waits between the front and the back
    typedef struct packed {
        logic [2:0]        sector;
        logic [DIST_W-1:0] gap;
        logic [PCT_W-1:0]  sat;
        logic [PCT_W-1:0]  val;
    } hsv2rgb_item_t;

endpackage

// File: hw/rtl/hsv2rgb_front.sv
// Front end of the HSV to RGB converter: reduces the hue modulo 360, clamps
// saturation and value, and finds the sector. Depends on hsv2rgb_pkg.
module hsv2rgb_front
    import hsv2rgb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [HUE_W-1:0]    hue,
    input  logic signed [PCT_IN_W-1:0] saturation,
    input  logic signed [PCT_IN_W-1:0] brightness,
    output logic                       out_valid,
    input  logic                       out_ready,
    output hsv2rgb_item_t              out_item
);

    logic                 valid_reg;
    logic [16:0]          u_reg;
    logic [7:0]           q_reg;
    logic [PCT_W-1:0]     sat_reg;
    logic [PCT_W-1:0]     val_reg;

    logic [17:0]          hue_ext;
    logic [17:0]          u_sum;
    logic [16:0]          u_next;
    logic [33:0]          hue_prod;
    logic [PCT_W-1:0]     sat_next;
    logic [PCT_W-1:0]     val_next;
    logic [16:0]          q_times_360;
    logic [16:0]          hu_wide;
    logic [8:0]           hu;
    logic [8:0]           sector_base;
    logic [8:0]           d_wide;
    logic [6:0]           d;
    logic [2:0]           sector;
    logic [DIST_W-1:0]    gap;

    // Offset the hue so that it is non-negative, then estimate hue / 360.
    always_comb
    begin
        hue_ext  = {{2{hue[HUE_W-1]}}, hue};
        u_sum    = hue_ext + 18'(HUE_OFFSET);
        u_next   = u_sum[16:0];
        hue_prod = 34'(u_next) * 34'(HUE_RECIP);
    end

    // Clamp both percentages to 0..100.
    always_comb
    begin
        if (saturation[PCT_IN_W-1])
            sat_next = '0;
        else if (saturation[PCT_W-1:0] > 7'd100)
            sat_next = 7'd100;
        else
            sat_next = saturation[PCT_W-1:0];

        if (brightness[PCT_IN_W-1])
            val_next = '0;
        else if (brightness[PCT_W-1:0] > 7'd100)
            val_next = 7'd100;
        else
            val_next = brightness[PCT_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    // Input stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            u_reg   <= u_next;
            q_reg   <= hue_prod[HUE_RECIP_SH+7:HUE_RECIP_SH];
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    // Remainder, sector and distance from the sector pair's midpoint.
    always_comb
    begin
        q_times_360 = 17'(q_reg) * 17'd360;
        hu_wide     = u_reg - q_times_360;
        hu          = hu_wide[8:0];

        if (hu < 9'd60)
            sector = SECTOR_RED_YELLOW;
        else if (hu < 9'd120)
            sector = SECTOR_YELLOW_GREEN;
        else if (hu < 9'd180)
            sector = SECTOR_GREEN_CYAN;
        else if (hu < 9'd240)
            sector = SECTOR_CYAN_BLUE;
        else if (hu < 9'd300)
            sector = SECTOR_BLUE_MAGENTA;
        else
            sector = SECTOR_MAGENTA_RED;

        if (hu >= 9'd240)
            sector_base = 9'd240;
        else if (hu >= 9'd120)
            sector_base = 9'd120;
        else
            sector_base = 9'd0;

        d_wide = hu - sector_base;
        d      = d_wide[6:0];

        if (d >= 7'd60)
            gap = DIST_W'(d - 7'd60);
        else
            gap = DIST_W'(7'd60 - d);
    end

    assign out_valid       = valid_reg;
    assign out_item.sector = sector;
    assign out_item.gap    = gap;
    assign out_item.sat    = sat_reg;
    assign out_item.val    = val_reg;

    // The reciprocal estimate must leave a true remainder.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> hu_wide < 17'd360)
        else $error("hue remainder out of range");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> gap <= 6'd60)
        else $error("sector distance out of range");

endmodule

// File: hw/rtl/hsv2rgb_queue.sv
// Short queue between the front and the back of the HSV to RGB converter.
// Register-based ring buffer; depends on hsv2rgb_pkg.
module hsv2rgb_queue
    import hsv2rgb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  hsv2rgb_item_t push_item,
    output logic          pop_valid,
    input  logic          pop_ready,
    output hsv2rgb_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsv2rgb_item_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                if (wr_ptr_reg == PTR_W'(DEPTH - 1))
                    wr_ptr_reg <= '0;
                else
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                if (rd_ptr_reg == PTR_W'(DEPTH - 1))
                    rd_ptr_reg <= '0;
                else
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
                count_reg <= count_reg + 1'b1;
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

// File: hw/rtl/hsv2rgb_back.sv
// Back end of the HSV to RGB converter: chroma, secondary and offset terms,
// channel selection and rounding, ending in the output register.
// Depends on hsv2rgb_pkg.
module hsv2rgb_back
    import hsv2rgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hsv2rgb_item_t     in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue
);

    // Stage 1: s * v
    logic              b1_valid_reg;
    logic [13:0]       sv_reg;
    logic [2:0]        b1_sector_reg;
    logic [DIST_W-1:0] b1_dist_reg;
    logic [PCT_W-1:0]  b1_val_reg;

    // Stage 2: chroma, secondary and offset numerators
    logic              b2_valid_reg;
    logic [NUM_W-1:0]  c_reg;
    logic [NUM_W-1:0]  x_reg;
    logic [NUM_W-1:0]  m_reg;
    logic [2:0]        b2_sector_reg;

    // Stage 3: output register
    logic              b3_valid_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;

    logic              b1_ready;
    logic              b2_ready;
    logic              b3_ready;

    logic [NUM_W-1:0]  c_next;
    logic [NUM_W-1:0]  x_next;
    logic [NUM_W-1:0]  vm_next;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  g_num;
    logic [NUM_W-1:0]  b_num;

    // Round-half-up of 255*(n + m)/600000.
    function automatic logic [CHAN_W-1:0] to_byte(input logic [NUM_W-1:0] n,
                                                  input logic [NUM_W-1:0] m);
        logic [NUM_W:0] sum;
        logic [24:0]    scaled;
        logic [17:0]    shifted;
        logic [36:0]    prod;
        sum     = {1'b0, n} + {1'b0, m};
        scaled  = 25'(sum[NUM_W-1:0]) * 25'd17 + 25'(ROUND_BIAS);
        shifted = scaled[23:6];
        prod    = 37'(shifted) * 37'(ROUND_RECIP);
        return prod[ROUND_RECIP_SH+7:ROUND_RECIP_SH];
    endfunction

    assign b3_ready = !b3_valid_reg || out_ready;
    assign b2_ready = !b2_valid_reg || b3_ready;
    assign b1_ready = !b1_valid_reg || b2_ready;
    assign in_ready = b1_ready;

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_ready)
                b1_valid_reg <= in_valid;
            if (b2_ready)
                b2_valid_reg <= b1_valid_reg;
            if (b3_ready)
                b3_valid_reg <= b2_valid_reg;
        end
    end

    // Stage 1: product of the two percentages.
    always_ff @(posedge clk)
    begin
        if (b1_ready && in_valid)
        begin
            sv_reg        <= 14'(in_item.sat) * 14'(in_item.val);
            b1_sector_reg <= in_item.sector;
            b1_dist_reg   <= in_item.gap;
            b1_val_reg    <= in_item.val;
        end
    end

    // Stage 2: C = sv*60, X = sv*(60 - dist), m = v*6000 - C.
    always_comb
    begin
        c_next  = NUM_W'(sv_reg) * NUM_W'(60);
        x_next  = NUM_W'(sv_reg) * NUM_W'(6'd60 - b1_dist_reg);
        vm_next = NUM_W'(b1_val_reg) * NUM_W'(6000);
    end

    always_ff @(posedge clk)
    begin
        if (b2_ready && b1_valid_reg)
        begin
            c_reg         <= c_next;
            x_reg         <= x_next;
            m_reg         <= vm_next - c_next;
            b2_sector_reg <= b1_sector_reg;
        end
    end

    // Sector decoder: route C and X to the channels.
    always_comb
    begin
        unique case (b2_sector_reg)
            SECTOR_RED_YELLOW:
            begin
                r_num = c_reg; g_num = x_reg; b_num = '0;
            end
            SECTOR_YELLOW_GREEN:
            begin
                r_num = x_reg; g_num = c_reg; b_num = '0;
            end
            SECTOR_GREEN_CYAN:
            begin
                r_num = '0; g_num = c_reg; b_num = x_reg;
            end
            SECTOR_CYAN_BLUE:
            begin
                r_num = '0; g_num = x_reg; b_num = c_reg;
            end
            SECTOR_BLUE_MAGENTA:
            begin
                r_num = x_reg; g_num = '0; b_num = c_reg;
            end
            SECTOR_MAGENTA_RED:
            begin
                r_num = c_reg; g_num = '0; b_num = x_reg;
            end
            default:
            begin
                r_num = '0; g_num = '0; b_num = '0;
            end
        endcase
    end

    // Stage 3: rounded channels into the output register.
    always_ff @(posedge clk)
    begin
        if (b3_ready && b2_valid_reg)
        begin
            red_reg   <= to_byte(r_num, m_reg);
            green_reg <= to_byte(g_num, m_reg);
            blue_reg  <= to_byte(b_num, m_reg);
        end
    end

    assign out_valid = b3_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    a_x_le_c: assert property (@(posedge clk) disable iff (!rst_n)
        b2_valid_reg |-> x_reg <= c_reg)
        else $error("secondary term exceeds chroma");

    a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
        b2_valid_reg |-> ({1'b0, c_reg} + {1'b0, m_reg}) <= 21'd600000)
        else $error("channel numerator exceeds denominator");

endmodule

// File: hw/rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter.
// Instantiates hsv2rgb_front, hsv2rgb_queue and hsv2rgb_back; uses hsv2rgb_pkg.
//
// Usage:
//   The slave stream carries one HSV item per transfer: tdata holds hue
//   (signed 16 bits, any value, reduced modulo 360), saturation and
//   brightness (signed 8-bit percents, clamped to 0..100). The master stream
//   returns one RGB item per input item, in order.
//   Throughput is one item per clock cycle while m_axis_tready stays high;
//   every stage is pipelined, so a new item enters each cycle while earlier
//   ones are still in flight. With no stall, an accepted item passes one
//   front register (hue reciprocal multiply), then the queue and three back
//   stages (s*v, chroma terms, rounding multiply) before tvalid on the output.
//   When the receiver holds tready low, the output register keeps its item,
//   the back stages and the queue fill up, and only then does s_axis_tready
//   fall; the front and back stall independently through the queue.
//   Reset clears all valid bits and the queue; no item is in flight after it.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // hue[15:0], saturation[23:16], brightness[31:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // red[7:0], green[15:8], blue[23:16]
);

    logic          fq_valid;
    logic          fq_ready;
    hsv2rgb_item_t fq_item;
    logic          qb_valid;
    logic          qb_ready;
    hsv2rgb_item_t qb_item;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    // Front: hue reduction, clamping and sector classification.
    hsv2rgb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .hue        (s_axis_tdata[15:0]),
        .saturation (s_axis_tdata[23:16]),
        .brightness (s_axis_tdata[31:24]),
        .out_valid  (fq_valid),
        .out_ready  (fq_ready),
        .out_item   (fq_item)
    );

    // Queue that decouples the front from the back.
    hsv2rgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // Back: arithmetic, rounding and output register.
    hsv2rgb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule
